// ----- sv/lisrs_pkg.sv -----
// Shared constants, codes and controller/datapath signal groups for the strip sequencer.
`default_nettype none
package lisrs_pkg;

    // strip geometry
    localparam int MAX_PIXELS     = 1024;
    localparam int STEPS_PER_TICK = 4;
    localparam int PIX_W          = $clog2(MAX_PIXELS);
    localparam int HALF_W         = PIX_W - 1;
    localparam int COUNT_W        = 11;
    localparam int DIVIDEND_W     = 2 * HALF_W;
    localparam int DIV_CNT_W      = $clog2(DIVIDEND_W + 1);
    localparam int STEP_W         = $clog2(STEPS_PER_TICK + 1);

    // field widths
    localparam int TIME_W   = 32;
    localparam int COLOR_W  = 24;
    localparam int BRIGHT_W = 8;
    localparam int IVAL_W   = 8;

    // behavior constants
    localparam int MIN_PIXELS    = 22;
    localparam int BASE_INDEX    = 10;
    localparam int HIT_HOLD_MS   = 140;
    localparam int BRIGHT_NORMAL = 150;
    localparam int BRIGHT_HIT    = 200;
    localparam logic [COLOR_W-1:0] WHITE       = 24'hFF_FFFF;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 24'h00_00FF;
    localparam int RESET_PIXELS   = 320;
    localparam int RESET_INTERVAL = 5;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_TOGGLE = 2'd1,
        MODE_HIT    = 2'd2,
        MODE_COLOR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [0:0] {
        CFG_PIXEL_COUNT   = 1'b0,
        CFG_STEP_INTERVAL = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        EM_PIX_LONG   = 3'd0,
        EM_PIX_SHORT  = 3'd1,
        EM_FILL_WHITE = 3'd2,
        EM_FILL_COLOR = 3'd3,
        EM_CLEAR      = 3'd4
    } t_emit;

    typedef struct packed {
        logic  latch_evt;
        logic  toggle;
        logic  hit_set;
        logic  hit_clear;
        logic  color_store;
        logic  step_start;
        logic  div_start;
        logic  advance;
        logic  anim_stop;
        logic  emit;
        t_emit emit_kind;
        logic  frame;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  is_on;
        logic  is_animating;
        logic  is_igniting;
        logic  in_hit;
        logic  hit_expired;
        logic  step_due;
        logic  pos_lt_long;
        logic  pos_last;
        logic  step_last;
        logic  step_full;
        logic  div_busy;
        logic  out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/lisrs_if.sv -----
// Handshake interfaces for the event, result and configuration channels.
`default_nettype none
interface lisrs_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [23:0] color_value;

    modport source (output valid, output mode, output now_ms, output color_value, input ready);
    modport sink   (input valid, input mode, input now_ms, input color_value, output ready);
endinterface

interface lisrs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [9:0]  pixel_index;
    logic [23:0] pixel_color;
    logic [7:0]  brightness;
    logic        frame_end;
    logic        last_of_run;

    modport source (output valid, output action, output pixel_index, output pixel_color,
                    output brightness, output frame_end, output last_of_run, input ready);
    modport sink   (input valid, input action, input pixel_index, input pixel_color,
                    input brightness, input frame_end, input last_of_run, output ready);
endinterface

interface lisrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/lisrs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the short-side scale.
`default_nettype none
module lisrs_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [lisrs_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  wire logic [lisrs_pkg::HALF_W-1:0]      i_divisor,
    output logic                                   o_busy,
    output logic [lisrs_pkg::HALF_W-1:0]           o_quotient
);
    logic                                r_busy;
    logic [lisrs_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [lisrs_pkg::HALF_W-1:0]        r_rem;
    logic [lisrs_pkg::DIVIDEND_W-1:0]    r_quo;
    logic [lisrs_pkg::HALF_W-1:0]        r_div;
    logic [lisrs_pkg::HALF_W:0]          w_shift;
    logic                                w_ge;

    // shift in next dividend bit and trial subtract
    assign w_shift = {r_rem, r_quo[lisrs_pkg::DIVIDEND_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= lisrs_pkg::DIV_CNT_W'(lisrs_pkg::DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == lisrs_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient; the remainder always stays below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? lisrs_pkg::HALF_W'(w_shift - {1'b0, r_div})
                          : w_shift[lisrs_pkg::HALF_W-1:0];
            r_quo <= {r_quo[lisrs_pkg::DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo[lisrs_pkg::HALF_W-1:0];
endmodule
`default_nettype wire

// ----- sv/lisrs_dp.sv -----
// Datapath: configuration, sequencer state, pixel index math and the output word register.
`default_nettype none
module lisrs_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lisrs_pkg::t_cmd                   i_cmd,
    output lisrs_pkg::t_status                     o_status,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [lisrs_pkg::TIME_W-1:0]      i_now_ms,
    input  wire logic [lisrs_pkg::COLOR_W-1:0]     i_color_value,
    input  wire logic                              i_cfg_valid,
    input  wire logic [0:0]                        i_cfg_index,
    input  wire logic [lisrs_pkg::COUNT_W-1:0]     i_cfg_data,
    input  wire logic                              i_res_ready,
    output logic                                   o_res_valid,
    output logic [1:0]                             o_action,
    output logic [lisrs_pkg::PIX_W-1:0]            o_pixel_index,
    output logic [lisrs_pkg::COLOR_W-1:0]          o_pixel_color,
    output logic [lisrs_pkg::BRIGHT_W-1:0]         o_brightness,
    output logic                                   o_frame_end,
    output logic                                   o_last_of_run
);
    localparam int PW = lisrs_pkg::PIX_W;
    localparam int HW = lisrs_pkg::HALF_W;
    localparam int CW = lisrs_pkg::COUNT_W;
    localparam int TW = lisrs_pkg::TIME_W;
    localparam int KW = lisrs_pkg::COLOR_W;
    localparam int DW = lisrs_pkg::DIVIDEND_W;
    localparam int SW = lisrs_pkg::STEP_W;

    // configuration
    logic [CW-1:0]                  r_pixel_count;
    logic [lisrs_pkg::IVAL_W-1:0]   r_interval;
    // latched event
    lisrs_pkg::t_mode               r_mode;
    logic [TW-1:0]                  r_now;
    logic [KW-1:0]                  r_color_in;
    // sequencer state
    logic                           r_is_on;
    logic                           r_anim;
    logic                           r_ign;
    logic [PW-1:0]                  r_pos;
    logic [TW-1:0]                  r_last_step;
    logic                           r_in_hit;
    logic [TW-1:0]                  r_hit_time;
    logic [KW-1:0]                  r_color;
    logic [SW-1:0]                  r_step_cnt;
    // output word
    logic                           r_out_valid;
    logic [1:0]                     r_action;
    logic [PW-1:0]                  r_index;
    logic [KW-1:0]                  r_pcolor;
    logic [lisrs_pkg::BRIGHT_W-1:0] r_bright;
    logic                           r_frame;
    logic                           r_last;

    logic [CW-1:0]                  w_count;
    logic [PW-1:0]                  w_long;
    logic [HW-1:0]                  w_long_m1;
    logic [HW-1:0]                  w_short_m1;
    logic [DW-1:0]                  w_prod;
    logic                           w_div_busy;
    logic [HW-1:0]                  w_sp;
    logic [PW-1:0]                  w_long_idx;
    logic [PW-1:0]                  w_short_idx;
    logic [KW-1:0]                  w_anim_color;
    logic [TW-1:0]                  w_hit_age;
    logic [TW-1:0]                  w_step_age;
    logic                           w_out_free;
    logic [1:0]                     n_action;
    logic [PW-1:0]                  n_index;
    logic [KW-1:0]                  n_pcolor;

    // saturate the pixel count and derive both sides
    always_comb begin
        if (r_pixel_count < CW'(lisrs_pkg::MIN_PIXELS)) begin
            w_count = CW'(lisrs_pkg::MIN_PIXELS);
        end else if (r_pixel_count > CW'(lisrs_pkg::MAX_PIXELS)) begin
            w_count = CW'(lisrs_pkg::MAX_PIXELS);
        end else begin
            w_count = r_pixel_count;
        end
    end
    assign w_long     = w_count[CW-1:1];
    assign w_long_m1  = HW'(w_long - PW'(1));
    assign w_short_m1 = HW'(w_long - PW'(lisrs_pkg::BASE_INDEX + 1));

    // short side scale: pos * (short-1) / (long-1)
    assign w_prod = DW'(r_pos[HW-1:0]) * DW'(w_short_m1);

    lisrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_long_m1),
        .o_busy     (w_div_busy),
        .o_quotient (w_sp)
    );

    // pixel indexes for this position
    always_comb begin
        if (r_ign) begin
            w_long_idx  = PW'(w_count - CW'(1) - {1'b0, r_pos});
            w_short_idx = PW'(lisrs_pkg::BASE_INDEX) + {1'b0, w_sp};
        end else begin
            w_long_idx  = w_long + r_pos;
            w_short_idx = w_long - PW'(1) - {1'b0, w_sp};
        end
    end
    assign w_anim_color = r_ign ? r_color : '0;

    // time checks with wraparound
    assign w_hit_age  = r_now - r_hit_time;
    assign w_step_age = r_now - r_last_step;
    assign w_out_free = !r_out_valid || i_res_ready;

    always_comb begin
        o_status.mode         = r_mode;
        o_status.is_on        = r_is_on;
        o_status.is_animating = r_anim;
        o_status.is_igniting  = r_ign;
        o_status.in_hit       = r_in_hit;
        o_status.hit_expired  = w_hit_age > TW'(lisrs_pkg::HIT_HOLD_MS);
        o_status.step_due     = w_step_age >= TW'(r_interval);
        o_status.pos_lt_long  = r_pos < w_long;
        o_status.pos_last     = ({1'b0, r_pos} + (PW+1)'(1)) >= {1'b0, w_long};
        o_status.step_last    = r_step_cnt == SW'(lisrs_pkg::STEPS_PER_TICK - 1);
        o_status.step_full    = r_step_cnt == SW'(lisrs_pkg::STEPS_PER_TICK);
        o_status.div_busy     = w_div_busy;
        o_status.out_free     = w_out_free;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= CW'(lisrs_pkg::RESET_PIXELS);
            r_interval    <= lisrs_pkg::IVAL_W'(lisrs_pkg::RESET_INTERVAL);
        end else if (i_cfg_valid) begin
            unique case (lisrs_pkg::t_cfg_reg'(i_cfg_index))
                lisrs_pkg::CFG_PIXEL_COUNT:   r_pixel_count <= i_cfg_data;
                lisrs_pkg::CFG_STEP_INTERVAL: r_interval <= i_cfg_data[lisrs_pkg::IVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // hold the accepted event
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_evt) begin
            r_mode     <= lisrs_pkg::t_mode'(i_mode);
            r_now      <= i_now_ms;
            r_color_in <= i_color_value;
        end
    end

    // sequencer state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_on     <= 1'b0;
            r_anim      <= 1'b0;
            r_ign       <= 1'b0;
            r_pos       <= '0;
            r_last_step <= '0;
            r_in_hit    <= 1'b0;
            r_hit_time  <= '0;
            r_color     <= lisrs_pkg::RESET_COLOR;
            r_step_cnt  <= '0;
        end else begin
            if (i_cmd.toggle) begin
                r_is_on     <= !r_is_on;
                r_ign       <= !r_is_on;
                r_anim      <= 1'b1;
                r_pos       <= '0;
                r_last_step <= r_now;
            end
            if (i_cmd.hit_set) begin
                r_in_hit   <= 1'b1;
                r_anim     <= 1'b1;
                r_hit_time <= r_now;
            end
            if (i_cmd.hit_clear) begin
                r_in_hit <= 1'b0;
                r_anim   <= 1'b0;
            end
            if (i_cmd.color_store) begin
                r_color <= r_color_in;
            end
            if (i_cmd.step_start) begin
                r_last_step <= r_now;
                r_step_cnt  <= '0;
            end
            if (i_cmd.advance) begin
                r_pos      <= r_pos + PW'(1);
                r_step_cnt <= r_step_cnt + SW'(1);
            end
            if (i_cmd.anim_stop) begin
                r_anim <= 1'b0;
            end
        end
    end

    // select the word to send
    always_comb begin
        unique case (i_cmd.emit_kind)
            lisrs_pkg::EM_PIX_LONG: begin
                n_action = lisrs_pkg::ACT_SET;
                n_index  = w_long_idx;
                n_pcolor = w_anim_color;
            end
            lisrs_pkg::EM_PIX_SHORT: begin
                n_action = lisrs_pkg::ACT_SET;
                n_index  = w_short_idx;
                n_pcolor = w_anim_color;
            end
            lisrs_pkg::EM_FILL_WHITE: begin
                n_action = lisrs_pkg::ACT_FILL;
                n_index  = PW'(lisrs_pkg::BASE_INDEX);
                n_pcolor = lisrs_pkg::WHITE;
            end
            lisrs_pkg::EM_FILL_COLOR: begin
                n_action = lisrs_pkg::ACT_FILL;
                n_index  = PW'(lisrs_pkg::BASE_INDEX);
                n_pcolor = r_color;
            end
            default: begin
                n_action = lisrs_pkg::ACT_CLEAR;
                n_index  = '0;
                n_pcolor = '0;
            end
        endcase
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_action <= n_action;
            r_index  <= n_index;
            r_pcolor <= n_pcolor;
            r_bright <= r_in_hit ? lisrs_pkg::BRIGHT_W'(lisrs_pkg::BRIGHT_HIT)
                                 : lisrs_pkg::BRIGHT_W'(lisrs_pkg::BRIGHT_NORMAL);
            r_frame  <= i_cmd.frame;
            r_last   <= i_cmd.last;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_pixel_index = r_index;
    assign o_pixel_color = r_pcolor;
    assign o_brightness  = r_bright;
    assign o_frame_end   = r_frame;
    assign o_last_of_run = r_last;
endmodule
`default_nettype wire

// ----- sv/lisrs_ctrl.sv -----
// Controller state machine: decodes each event and sequences the words it causes.
`default_nettype none
module lisrs_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_evt_valid,
    output logic                     o_evt_ready,
    input  wire lisrs_pkg::t_status  i_status,
    output lisrs_pkg::t_cmd          o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_LOOP   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_PIX_A  = 8'b0001_0000,
        S_PIX_B  = 8'b0010_0000,
        S_FILL   = 8'b0100_0000,
        S_CLEAR  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_frame;

    // last pixel of this tick shows the strip
    assign w_frame = i_status.step_last || i_status.pos_last;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_kind = lisrs_pkg::EM_CLEAR;
        unique case (r_state)
            S_IDLE: begin
                if (i_evt_valid) begin
                    o_cmd.latch_evt = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_status.mode)
                    lisrs_pkg::MODE_TICK: begin
                        if (i_status.in_hit) begin
                            if (i_status.hit_expired) begin
                                o_cmd.hit_clear = 1'b1;
                                n_state = S_FILL;
                            end
                        end else if (i_status.is_animating && i_status.step_due) begin
                            o_cmd.step_start = 1'b1;
                            n_state = S_LOOP;
                        end
                    end
                    lisrs_pkg::MODE_TOGGLE: begin
                        o_cmd.toggle = 1'b1;
                    end
                    lisrs_pkg::MODE_HIT: begin
                        if (i_status.is_on) begin
                            o_cmd.hit_set = 1'b1;
                            n_state = S_FILL;
                        end
                    end
                    lisrs_pkg::MODE_COLOR: begin
                        o_cmd.color_store = 1'b1;
                        if (i_status.is_on && !i_status.is_animating) begin
                            n_state = S_FILL;
                        end
                    end
                endcase
            end
            S_LOOP: begin
                if (i_status.pos_lt_long && !i_status.step_full) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (!i_status.pos_lt_long) begin
                    o_cmd.anim_stop = 1'b1;
                    n_state = i_status.is_igniting ? S_IDLE : S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_PIX_A;
                end
            end
            S_PIX_A: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = lisrs_pkg::EM_PIX_LONG;
                    n_state = S_PIX_B;
                end
            end
            S_PIX_B: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = lisrs_pkg::EM_PIX_SHORT;
                    o_cmd.frame     = w_frame;
                    o_cmd.last      = w_frame &&
                                      !(!i_status.is_igniting && i_status.pos_last);
                    o_cmd.advance   = 1'b1;
                    n_state = S_LOOP;
                end
            end
            S_FILL: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = (i_status.mode == lisrs_pkg::MODE_HIT)
                                      ? lisrs_pkg::EM_FILL_WHITE : lisrs_pkg::EM_FILL_COLOR;
                    o_cmd.frame     = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = lisrs_pkg::EM_CLEAR;
                    o_cmd.frame     = 1'b1;
                    o_cmd.last      = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_evt_ready = r_state == S_IDLE;
endmodule
`default_nettype wire

// ----- sv/led_strip_ignite_retract_sequencer_core.sv -----
// Top level of the strip ignite/retract sequencer: controller, datapath and port wiring.
// The block takes one event word at a time (tick, toggle, hit, colour) and sends the strip
// writes it causes as result words, the final one marked last_of_run. Toggle passes
// through the idle and decode states only; hit, hit expiry and colour refill also pass
// through the fill state and may wait there on the result side. An animation tick runs,
// for each of up to four positions, the one-bit-per-cycle divider that scales the short
// side and two pixel words, then the closing clear on retraction. Events are accepted whenever
// the sequencer is idle, even while the last result word still waits to be taken. Configuration
// writes are always ready and apply at once; write them only while no event is in progress.
`default_nettype none
module led_strip_ignite_retract_sequencer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lisrs_evt_if.sink  i_evt,
    lisrs_res_if.source o_res,
    lisrs_cfg_if.sink  i_cfg
);
    lisrs_pkg::t_cmd    w_cmd;
    lisrs_pkg::t_status w_status;
    logic               w_evt_ready;

    lisrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (i_evt.valid),
        .o_evt_ready (w_evt_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lisrs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_mode        (i_evt.mode),
        .i_now_ms      (i_evt.now_ms),
        .i_color_value (i_evt.color_value),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_res_ready   (o_res.ready),
        .o_res_valid   (o_res.valid),
        .o_action      (o_res.action),
        .o_pixel_index (o_res.pixel_index),
        .o_pixel_color (o_res.pixel_color),
        .o_brightness  (o_res.brightness),
        .o_frame_end   (o_res.frame_end),
        .o_last_of_run (o_res.last_of_run)
    );

    assign i_evt.ready = w_evt_ready;
    assign i_cfg.ready = 1'b1;
endmodule
`default_nettype wire

// ----- sv/lisrs_chk.sv -----
// Port-level checker for the strip sequencer, bound to the top level.
`default_nettype none
module lisrs_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  i_action,
    input wire logic [9:0]  i_pixel_index,
    input wire logic [23:0] i_pixel_color,
    input wire logic        i_frame_end,
    input wire logic        i_last_of_run
);
    // stalled word holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_action)
            && $stable(i_pixel_index) && $stable(i_pixel_color) && $stable(i_last_of_run))
        else $error("result word changed while stalled");

    // clear word is whole strip, shown, and ends its run
    a_clear_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action == lisrs_pkg::ACT_CLEAR |->
            i_pixel_index == '0 && i_pixel_color == '0 && i_frame_end && i_last_of_run)
        else $error("malformed clear word");

    // fill word starts at the base and ends its run
    a_fill_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action == lisrs_pkg::ACT_FILL |->
            i_pixel_index == 10'(lisrs_pkg::BASE_INDEX) && i_frame_end && i_last_of_run)
        else $error("malformed fill word");

    // a run never ends on an unshown pixel, and the unused action code never appears
    a_last_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_action == lisrs_pkg::ACT_SET || i_action == lisrs_pkg::ACT_FILL
            || i_action == lisrs_pkg::ACT_CLEAR) && (!i_last_of_run || i_frame_end))
        else $error("bad action or unshown last word");
endmodule

bind led_strip_ignite_retract_sequencer_core lisrs_chk u_lisrs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_action      (o_res.action),
    .i_pixel_index (o_res.pixel_index),
    .i_pixel_color (o_res.pixel_color),
    .i_frame_end   (o_res.frame_end),
    .i_last_of_run (o_res.last_of_run)
);
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the strip ignite/retract sequencer: directed cases, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W    = lisrs_pkg::PIX_W;
    localparam int COLOR_W  = lisrs_pkg::COLOR_W;
    localparam int BRIGHT_W = lisrs_pkg::BRIGHT_W;
    localparam int COUNT_W  = lisrs_pkg::COUNT_W;
    localparam int IVAL_W   = lisrs_pkg::IVAL_W;
    localparam int TIME_W   = lisrs_pkg::TIME_W;

    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 204;

    typedef struct packed {
        lisrs_pkg::t_action   action;
        logic [PIX_W-1:0]     index;
        logic [COLOR_W-1:0]   color;
        logic [BRIGHT_W-1:0]  bright;
        logic                 frame;
        logic                 last;
    } t_strip_write;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lisrs_evt_if evt_if();
    lisrs_res_if res_if();
    lisrs_cfg_if cfg_if();

    led_strip_ignite_retract_sequencer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    // Predicted configuration and sequencer state
    logic [COUNT_W-1:0]  cfg_pixels   = COUNT_W'(lisrs_pkg::RESET_PIXELS);
    logic [IVAL_W-1:0]   cfg_interval = IVAL_W'(lisrs_pkg::RESET_INTERVAL);
    logic                strip_on     = 1'b0;
    logic                anim_run     = 1'b0;
    logic                anim_ignite  = 1'b0;
    logic [PIX_W-1:0]    anim_pos     = '0;
    logic [TIME_W-1:0]   step_time    = '0;
    logic                hit_active   = 1'b0;
    logic [TIME_W-1:0]   hit_time     = '0;
    logic [COLOR_W-1:0]  blade_color  = lisrs_pkg::RESET_COLOR;

    // Writes caused by the event being predicted, then the queue of writes still to arrive
    t_strip_write run_buf [0:15];
    int           run_len;
    t_strip_write strip_writes_q [$];

    int n_mismatch  = 0;
    int n_sent      = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int stall_max   = 0;

    function automatic void add_write(lisrs_pkg::t_action act, int idx,
                                      logic [COLOR_W-1:0] col, logic frame);
        logic [BRIGHT_W-1:0] br;
        br = hit_active ? BRIGHT_W'(lisrs_pkg::BRIGHT_HIT)
                        : BRIGHT_W'(lisrs_pkg::BRIGHT_NORMAL);
        run_buf[run_len] = '{action: act, index: PIX_W'(idx), color: col,
                             bright: br, frame: frame, last: 1'b0};
        run_len++;
    endfunction

    // Advance the predicted state by one event and queue the writes it causes
    task automatic predict_strip_writes(lisrs_pkg::t_mode mode, logic [TIME_W-1:0] now,
                                        logic [COLOR_W-1:0] col);
        int count, long_side, short_side, scaled, pos, i;
        logic [TIME_W-1:0] dt;
        run_len = 0;
        case (mode)
            lisrs_pkg::MODE_TICK: begin
                if (hit_active) begin
                    dt = now - hit_time;
                    if (dt > TIME_W'(lisrs_pkg::HIT_HOLD_MS)) begin
                        hit_active = 1'b0;
                        anim_run   = 1'b0;
                        add_write(lisrs_pkg::ACT_FILL, lisrs_pkg::BASE_INDEX, blade_color, 1'b1);
                    end
                end else if (anim_run) begin
                    dt = now - step_time;
                    if (dt >= TIME_W'(cfg_interval)) begin
                        step_time = now;
                        count = int'(cfg_pixels);
                        if (count < lisrs_pkg::MIN_PIXELS) count = lisrs_pkg::MIN_PIXELS;
                        if (count > lisrs_pkg::MAX_PIXELS) count = lisrs_pkg::MAX_PIXELS;
                        long_side  = count / 2;
                        short_side = count / 2 - lisrs_pkg::BASE_INDEX;
                        for (i = 0; i < lisrs_pkg::STEPS_PER_TICK && int'(anim_pos) < long_side;
                             i++) begin
                            pos    = int'(anim_pos);
                            scaled = (pos * (short_side - 1)) / (long_side - 1);
                            if (anim_ignite) begin
                                add_write(lisrs_pkg::ACT_SET, count - 1 - pos, blade_color,
                                          1'b0);
                                add_write(lisrs_pkg::ACT_SET, lisrs_pkg::BASE_INDEX + scaled,
                                          blade_color, 1'b0);
                            end else begin
                                add_write(lisrs_pkg::ACT_SET, count / 2 + pos, '0, 1'b0);
                                add_write(lisrs_pkg::ACT_SET, count / 2 - 1 - scaled, '0, 1'b0);
                            end
                            anim_pos = anim_pos + 1'b1;
                        end
                        if (run_len > 0) run_buf[run_len-1].frame = 1'b1;
                        if (int'(anim_pos) >= long_side) begin
                            anim_run = 1'b0;
                            if (!anim_ignite) add_write(lisrs_pkg::ACT_CLEAR, 0, '0, 1'b1);
                        end
                    end
                end
            end
            lisrs_pkg::MODE_TOGGLE: begin
                strip_on    = !strip_on;
                anim_ignite = strip_on;
                anim_run    = 1'b1;
                anim_pos    = '0;
                step_time   = now;
            end
            lisrs_pkg::MODE_HIT: begin
                if (strip_on) begin
                    hit_active = 1'b1;
                    anim_run   = 1'b1;
                    hit_time   = now;
                    add_write(lisrs_pkg::ACT_FILL, lisrs_pkg::BASE_INDEX, lisrs_pkg::WHITE, 1'b1);
                end
            end
            default: begin
                blade_color = col;
                if (strip_on && !anim_run) begin
                    add_write(lisrs_pkg::ACT_FILL, lisrs_pkg::BASE_INDEX, blade_color, 1'b1);
                end
            end
        endcase
        if (run_len > 0) run_buf[run_len-1].last = 1'b1;
        for (i = 0; i < run_len; i++) strip_writes_q.push_back(run_buf[i]);
    endtask

    // Send one event word, idling between bursts, and predict it once accepted
    task automatic send_event(lisrs_pkg::t_mode mode, logic [TIME_W-1:0] now,
                              logic [COLOR_W-1:0] col);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                evt_if.valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        evt_if.valid       <= 1'b1;
        evt_if.mode        <= mode;
        evt_if.now_ms      <= now;
        evt_if.color_value <= col;
        @(posedge i_clk);
        while (!evt_if.ready) @(posedge i_clk);
        predict_strip_writes(mode, now, col);
        n_sent++;
    endtask

    // Hold events until every expected write has arrived and the block has settled
    task automatic wait_idle();
        evt_if.valid <= 1'b0;
        while (strip_writes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_cfg(logic [COUNT_W-1:0] pixels, logic [IVAL_W-1:0] interval);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= lisrs_pkg::CFG_PIXEL_COUNT;
        cfg_if.data  <= pixels;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_pixels = pixels;
        cfg_if.index <= lisrs_pkg::CFG_STEP_INTERVAL;
        cfg_if.data  <= COUNT_W'(interval);
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_interval = interval;
        cfg_if.valid <= 1'b0;
    endtask

    // Reset defaults: events while off, then a first ignition tick at 320 pixels
    task automatic test_power_on_defaults();
        send_event(lisrs_pkg::MODE_HIT, 32'd1, 24'h000000);
        send_event(lisrs_pkg::MODE_COLOR, 32'd2, 24'hFF_FFFF);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'd3, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'd8, 24'h000000);
    endtask

    // Shortest strip: finish ignition, colour refill, hit with toggle inside it, hit expiry
    task automatic test_short_strip_hit();
        stall_max = 3;
        set_cfg(11'd22, 8'd0);
        send_event(lisrs_pkg::MODE_TICK, 32'd8, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'd8, 24'h000000);
        send_event(lisrs_pkg::MODE_COLOR, 32'd9, 24'h00A5_5A);
        send_event(lisrs_pkg::MODE_HIT, 32'd100, 24'h000000);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'd150, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'd240, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'd241, 24'h000000);
    endtask

    // Retraction with the widest interval across the timestamp wrap, colour held while animating
    task automatic test_retract_across_wrap();
        gap_max = 4;
        set_cfg(11'd22, 8'd255);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'hFFFF_FF00, 24'h000000);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'hFFFF_FF80, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_007E, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_007F, 24'h000000);
        send_event(lisrs_pkg::MODE_COLOR, 32'h0000_0080, 24'h12_3456);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_017E, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_027D, 24'h000000);
    endtask

    // Count saturated high, then lowered mid-retraction so only the clear remains
    task automatic test_count_saturation();
        stall_max = 12;
        set_cfg(11'd2047, 8'd0);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'h0000_1000, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_1000, 24'h000000);
        send_event(lisrs_pkg::MODE_TOGGLE, 32'h0000_1001, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_1001, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_1002, 24'h000000);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_1003, 24'h000000);
        set_cfg(11'd0, 8'd0);
        send_event(lisrs_pkg::MODE_TICK, 32'h0000_1004, 24'h000000);
    endtask

    // Random phases: a fresh setting each, mostly well-formed event streams plus noise
    task automatic test_random_traffic();
        logic [TIME_W-1:0]  t;
        logic [COUNT_W-1:0] pixels;
        logic [IVAL_W-1:0]  interval;
        int stop_at, phase, n_items, k, r, step;
        stop_at = n_sent + RANDOM_ITEMS;
        phase   = 0;
        while (n_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0:       pixels = COUNT_W'($urandom_range(0, 21));
                1:       pixels = COUNT_W'($urandom_range(1024, 2047));
                2:       pixels = COUNT_W'($urandom_range(65, 1023));
                default: pixels = COUNT_W'($urandom_range(22, 64));
            endcase
            case ($urandom_range(0, 9))
                0, 1:    interval = 8'd0;
                2:       interval = 8'd255;
                3:       interval = IVAL_W'($urandom_range(0, 255));
                default: interval = IVAL_W'($urandom_range(1, 10));
            endcase
            set_cfg(pixels, interval);
            if (phase == 0) begin
                gap_max   = 0;
                stall_max = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 12;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_max = 0;
                    1: stall_max = 4;
                    default: stall_max = 20;
                endcase
            end
            t       = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
            n_items = $urandom_range(20, 35);
            for (k = 0; k < n_items && n_sent < stop_at; k++) begin
                // hold the sender once until every write of this phase has come
                if (phase == 1 && k == n_items / 2) begin
                    evt_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (strip_writes_q.size() != 0) @(posedge i_clk);
                end
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    send_event(lisrs_pkg::MODE_TOGGLE, t, 24'($urandom));
                end else if (r < 10) begin
                    send_event(lisrs_pkg::MODE_HIT, t, 24'($urandom));
                end else if (r < 15) begin
                    send_event(lisrs_pkg::MODE_COLOR, t, 24'($urandom));
                end else if (r < 22) begin
                    send_event(lisrs_pkg::t_mode'($urandom_range(0, 3)), $urandom,
                               24'($urandom));
                end else begin
                    if ($urandom_range(0, 9) == 0) step = $urandom_range(100, 300);
                    else step = $urandom_range(0, int'(cfg_interval) * 2 + 2);
                    t = t + TIME_W'(step);
                    send_event(lisrs_pkg::MODE_TICK, t, 24'($urandom));
                end
            end
            phase++;
        end
    endtask

    // Receiver: ready in short runs with stalls of random length between them
    initial begin
        res_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if (stall_max > 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, stall_max)) @(posedge i_clk);
            end
        end
    end

    task automatic flag_mismatch(string msg);
        if (n_mismatch < 10) $display("%s", msg);
        n_mismatch++;
    endtask

    // Compare each accepted result word against the oldest expected write
    always @(posedge i_clk) begin : check_results
        t_strip_write got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{action: lisrs_pkg::t_action'(res_if.action), index: res_if.pixel_index,
                    color: res_if.pixel_color, bright: res_if.brightness,
                    frame: res_if.frame_end, last: res_if.last_of_run};
            if (strip_writes_q.size() == 0) begin
                flag_mismatch($sformatf(
                    "unexpected write: act=%0d idx=%0d col=%06h br=%0d fe=%0b last=%0b",
                    got.action, got.index, got.color, got.bright, got.frame, got.last));
            end else begin
                want = strip_writes_q.pop_front();
                if (got !== want) begin
                    flag_mismatch($sformatf(
                        {"write mismatch: got act=%0d idx=%0d col=%06h br=%0d fe=%0b last=%0b",
                         " want act=%0d idx=%0d col=%06h br=%0d fe=%0b last=%0b"},
                        got.action, got.index, got.color, got.bright, got.frame, got.last,
                        want.action, want.index, want.color, want.bright, want.frame,
                        want.last));
                end
            end
        end
    end

    // Drop the run if it hangs
    initial begin
        #(64'd12_000_000);
        $display("** led_strip_ignite_retract_sequencer_core: FAILED **");
        $finish;
    end

    initial begin
        evt_if.valid       <= 1'b0;
        evt_if.mode        <= lisrs_pkg::MODE_TICK;
        evt_if.now_ms      <= '0;
        evt_if.color_value <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= lisrs_pkg::CFG_PIXEL_COUNT;
        cfg_if.data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_defaults();
        test_short_strip_hit();
        test_retract_across_wrap();
        test_count_saturation();
        test_random_traffic();

        evt_if.valid <= 1'b0;
        while (strip_writes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && strip_writes_q.size() == 0) begin
            $display("** led_strip_ignite_retract_sequencer_core: PASSED **");
        end else begin
            $display("** led_strip_ignite_retract_sequencer_core: FAILED **");
        end
        $finish;
    end

endmodule
